[design/rdb_pkg.sv]
// rdb_pkg: shared types and constants of the rms dB level meter.
// Item structs, multiplier request/response, sequencer enums, register indexes.
// No dependencies.
package rdb_pkg;

  // Field widths fixed by the item format
  localparam int SAMPLE_W     = 16;
  localparam int LEVEL_W      = 16;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int BPL_FIELD_W  = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_LONG = 2'd1;

  // Reset values of the configuration registers
  localparam int BL_RESET  = 200;
  localparam int BPL_RESET = 10;

  // Digit-serial multiplier: A times B, B consumed MSB digit first
  localparam int DIGIT_W    = 8;
  localparam int MUL_A_W    = 31;
  localparam int MUL_B_W    = 32;
  localparam int MUL_P_W    = 63;
  localparam int MUL_DIGITS = MUL_B_W / DIGIT_W;

  // log2: Q1.30 mantissa, 24 fraction bits
  localparam int MANT_W   = 31;
  localparam int LOG_FRAC = 24;

  // 10*log10(2) in Q28
  localparam logic [MUL_A_W-1:0] K_Q28 = 31'd808071242;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
  } sample_item_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] block_level;
    logic                      block_silent;
    logic                      long_valid;
    logic signed [LEVEL_W-1:0] long_level;
    logic                      long_silent;
  } level_item_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] p;
  } mul_rsp_t;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQUARE,
    LG_WAIT
  } log_state_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_SMP_MUL,
    SQ_SMP_WAIT,
    SQ_CHECK,
    SQ_LOG_START,
    SQ_LOG_WAIT,
    SQ_LVL_MUL,
    SQ_LVL_WAIT,
    SQ_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {
    JOB_BLOCK_ENERGY,
    JOB_BLOCK_DIV,
    JOB_LONG_ENERGY,
    JOB_LONG_DIV
  } job_t;

endpackage

[design/rdb_chan_if.sv]
// rdb_chan_if: valid/ready channels of the level meter, one per item type.
// Depends on rdb_pkg for the item structs.
interface rdb_sample_if import rdb_pkg::*;;
  logic         valid;
  logic         ready;
  sample_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rdb_level_if import rdb_pkg::*;;
  logic        valid;
  logic        ready;
  level_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/rdb_digit_mul.sv]
// rdb_digit_mul: 31 x 32 bit multiplier, one 8-bit digit of B per cycle.
// Depends on rdb_pkg (mul_req_t, mul_rsp_t, digit constants).
module rdb_digit_mul import rdb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(MUL_DIGITS);

  logic [MUL_A_W-1:0]         a_reg;
  logic [MUL_B_W-1:0]         b_sh;
  logic [MUL_P_W-1:0]         acc;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic                       done;
  logic [MUL_A_W+DIGIT_W-1:0] partial;
  logic                       last;

  // one partial product per cycle, top digit of B
  assign partial = a_reg * b_sh[MUL_B_W-1 -: DIGIT_W];
  assign last    = (cnt == CNT_W'(MUL_DIGITS - 1));

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-and-add datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      b_sh  <= req.b;
      acc   <= '0;
    end else if (busy) begin
      acc  <= {acc[MUL_P_W-DIGIT_W-1:0], DIGIT_W'(0)} + MUL_P_W'(partial);
      b_sh <= b_sh << DIGIT_W;
    end
  end

  assign rsp.done = done;
  assign rsp.p    = acc;

endmodule

[design/rdb_log2.sv]
// rdb_log2: log2 of a nonzero integer in Q24, bit-serial leading-one search
// then 24 mantissa squarings on the shared digit multiplier. Depends on rdb_pkg.
module rdb_log2 import rdb_pkg::*; #(
  parameter int X_W = 45
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [X_W-1:0]                    x,
  output logic                              done,
  output logic [$clog2(X_W)+LOG_FRAC-1:0]   result,
  output mul_req_t                          mul_req,
  input  mul_rsp_t                          mul_rsp
);

  localparam int E_W  = $clog2(X_W);
  localparam int IT_W = $clog2(LOG_FRAC);

  log_state_t          state;
  log_state_t          state_next;
  logic [X_W-1:0]      norm;
  logic [E_W-1:0]      e;
  logic [MANT_W-1:0]   m;
  logic [LOG_FRAC-1:0] frac;
  logic [IT_W-1:0]     it;
  logic                last_it;
  logic                sq_top;

  assign last_it = (it == IT_W'(LOG_FRAC - 1));
  // squared mantissa reached [2,4): renormalize and emit a one
  assign sq_top  = mul_rsp.p[2*MANT_W-1];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LG_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == LG_WAIT) && mul_rsp.done && last_it;
    end
  end

  // next state and multiplier request
  always_comb begin
    state_next    = state;
    mul_req.start = 1'b0;
    mul_req.a     = m;
    mul_req.b     = MUL_B_W'(m);
    case (state)
      LG_IDLE: begin
        if (start) state_next = LG_NORM;
      end
      LG_NORM: begin
        if (norm[X_W-1]) state_next = LG_SQUARE;
      end
      LG_SQUARE: begin
        mul_req.start = 1'b1;
        state_next    = LG_WAIT;
      end
      LG_WAIT: begin
        if (mul_rsp.done) state_next = last_it ? LG_IDLE : LG_SQUARE;
      end
      default: state_next = LG_IDLE;
    endcase
  end

  // normalize one bit per cycle, then collect fraction bits
  always_ff @(posedge clk) begin
    case (state)
      LG_IDLE: begin
        if (start) begin
          norm <= x;
          e    <= E_W'(X_W - 1);
          it   <= '0;
          frac <= '0;
        end
      end
      LG_NORM: begin
        if (norm[X_W-1]) begin
          m <= norm[X_W-1 -: MANT_W];
        end else begin
          norm <= norm << 1;
          e    <= e - 1'b1;
        end
      end
      LG_WAIT: begin
        if (mul_rsp.done) begin
          it <= it + 1'b1;
          if (sq_top) begin
            m    <= mul_rsp.p[2*MANT_W-1 -: MANT_W];
            frac <= {frac[LOG_FRAC-2:0], 1'b1};
          end else begin
            m    <= mul_rsp.p[2*MANT_W-2 -: MANT_W];
            frac <= {frac[LOG_FRAC-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  assign result = {e, frac};

endmodule

[design/rms_db_level_meter.sv]
// rms_db_level_meter: block rms level and long-period Leq in 1/256 dB.
// Depends on rdb_pkg, rdb_chan_if, rdb_digit_mul, rdb_log2.
//
//   port      dir   item           handshake
//   samples   in    sample_item_t  valid/ready
//   levels    out   level_item_t   valid/ready, one item per closed block
//   cfg_*     in    register write cfg_we, no wait
//
// A sample that does not close a block is squared on the shared 31x8-bit
// digit multiplier. A closing sample adds two log2 runs (leading-one shift,
// then 24 squarings) and a scale multiply, twice that when it also closes a
// long period; an all-zero energy skips its log runs and multiply.
// Synchronous reset, no clearing pass. A result waiting on levels does not
// stop input until the next block close needs the output register.
module rms_db_level_meter import rdb_pkg::*; #(
  parameter int MAX_BLOCK_LENGTH    = 1024,
  parameter int MAX_BLOCKS_PER_LONG = 16,
  parameter int LEVEL_FRAC_BITS     = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rdb_sample_if.sink            samples,
  rdb_level_if.source           levels
);

  localparam int BL_CAP   = (MAX_BLOCK_LENGTH > BL_RESET) ? MAX_BLOCK_LENGTH : BL_RESET;
  localparam int BPL_CAP  = (MAX_BLOCKS_PER_LONG > BPL_RESET) ? MAX_BLOCKS_PER_LONG
                                                                : BPL_RESET;
  localparam int BL_W     = $clog2(BL_CAP + 1);
  localparam int BPL_W    = $clog2(BPL_CAP + 1);
  localparam int BE_W     = $clog2(BL_CAP) + 2 * SAMPLE_W - 1;
  localparam int LE_W     = BE_W + $clog2(BPL_CAP);
  localparam int LOG_W    = $clog2(LE_W) + LOG_FRAC;
  localparam int SH       = 52 - LEVEL_FRAC_BITS;
  localparam int R_W      = MUL_P_W - SH;
  localparam int LMIN_RAW = (9000 << LEVEL_FRAC_BITS) >> 8;
  localparam int LMIN_MAG = (LMIN_RAW > 32768) ? 32768 : LMIN_RAW;
  localparam int LMAX_RAW = (23200 << LEVEL_FRAC_BITS) >> 8;
  localparam int LMAX     = (LMAX_RAW > 32767) ? 32767 : LMAX_RAW;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = LEVEL_W'(0) - LEVEL_W'(LMIN_MAG);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(LMAX);

  seq_state_t           state;
  seq_state_t           state_next;
  job_t                 job;

  logic [BL_W-1:0]      block_length;
  logic [BPL_W-1:0]     blocks_per_long;
  logic [BL_W-1:0]      bl_wr;
  logic [BPL_W-1:0]     bpl_wr;

  logic [SAMPLE_W-1:0]  mag;
  logic [SAMPLE_W-1:0]  mag_in;
  logic [BE_W-1:0]      block_energy;
  logic [LE_W-1:0]      long_energy;
  logic [BL_W-1:0]      sample_index;
  logic [BPL_W-1:0]     block_index;
  logic [BL_W:0]        sidx_inc;
  logic [BPL_W:0]       bidx_inc;
  logic                 blk_close;
  logic                 long_close_now;
  logic [LE_W-1:0]      long_sum;

  logic [BE_W-1:0]      e_blk;
  logic [LE_W-1:0]      e_long;
  logic                 long_close;
  logic [BL_W+BPL_W-1:0] div_long;
  logic [LE_W-1:0]      log_x;
  logic                 log_start;
  logic                 log_done;
  logic [LOG_W-1:0]     log_res;
  logic [LOG_W-1:0]     la;
  logic [LOG_W-1:0]     lb;
  logic                 lvl_neg;
  logic [LOG_W-1:0]     lvl_mag;
  logic                 neg_reg;
  logic                 energy_zero;
  logic                 energy_job;

  logic [MUL_P_W-1:0]   rnd_sum;
  logic [R_W-1:0]       r;
  logic [LEVEL_W-1:0]   lvl;

  mul_req_t             top_req;
  mul_req_t             log_mul_req;
  mul_req_t             mul_req;
  mul_rsp_t             mul_rsp;

  level_item_t          res;
  level_item_t          out_data;
  logic                 out_valid;
  logic                 out_load;

  // shared multiplier, lent to the log unit while it runs
  assign mul_req = (state == SQ_LOG_WAIT) ? log_mul_req : top_req;

  rdb_digit_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  rdb_log2 #(.X_W(LE_W)) u_log (
    .clk     (clk),
    .rst     (rst),
    .start   (log_start),
    .x       (log_x),
    .done    (log_done),
    .result  (log_res),
    .mul_req (log_mul_req),
    .mul_rsp (mul_rsp)
  );

  // register writes: zero reads as one, large values clamp
  always_comb begin
    if (cfg_data == '0) begin
      bl_wr = BL_W'(1);
    end else if (32'(cfg_data) > MAX_BLOCK_LENGTH) begin
      bl_wr = BL_W'(MAX_BLOCK_LENGTH);
    end else begin
      bl_wr = BL_W'(cfg_data);
    end
    if (cfg_data[BPL_FIELD_W-1:0] == '0) begin
      bpl_wr = BPL_W'(1);
    end else if (32'(cfg_data[BPL_FIELD_W-1:0]) > MAX_BLOCKS_PER_LONG) begin
      bpl_wr = BPL_W'(MAX_BLOCKS_PER_LONG);
    end else begin
      bpl_wr = BPL_W'(cfg_data[BPL_FIELD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length    <= BL_W'(BL_RESET);
      blocks_per_long <= BPL_W'(BPL_RESET);
    end else if (cfg_we) begin
      if (cfg_index == REG_BLOCK_LENGTH)    block_length    <= bl_wr;
      if (cfg_index == REG_BLOCKS_PER_LONG) blocks_per_long <= bpl_wr;
    end
  end

  // sample magnitude; -32768 maps to 32768 unsigned
  assign mag_in = samples.data.sample[SAMPLE_W-1] ? (~samples.data.sample + 1'b1)
                                                   : samples.data.sample;

  // period counters
  assign sidx_inc       = {1'b0, sample_index} + 1'b1;
  assign bidx_inc       = {1'b0, block_index} + 1'b1;
  assign blk_close      = (sidx_inc >= {1'b0, block_length});
  assign long_close_now = (bidx_inc >= {1'b0, blocks_per_long});
  assign long_sum       = long_energy + LE_W'(block_energy);

  // log operand for the current job
  assign div_long   = block_length * blocks_per_long;
  assign energy_job = (job == JOB_BLOCK_ENERGY) || (job == JOB_LONG_ENERGY);
  always_comb begin
    case (job)
      JOB_BLOCK_ENERGY: log_x = LE_W'(e_blk);
      JOB_BLOCK_DIV:    log_x = LE_W'(block_length);
      JOB_LONG_ENERGY:  log_x = e_long;
      JOB_LONG_DIV:     log_x = LE_W'(div_long);
      default:          log_x = LE_W'(block_length);
    endcase
  end
  assign energy_zero = energy_job && (log_x == '0);

  // level difference sign and magnitude
  assign lvl_neg = (la < lb);
  assign lvl_mag = lvl_neg ? (lb - la) : (la - lb);

  // round to nearest and saturate
  assign rnd_sum = mul_rsp.p + (MUL_P_W'(1) << (SH - 1));
  assign r       = rnd_sum[MUL_P_W-1:SH];
  always_comb begin
    if (neg_reg) begin
      lvl = (32'(r) > LMIN_MAG) ? LEVEL_MIN : (LEVEL_W'(0) - LEVEL_W'(r));
    end else begin
      lvl = (32'(r) > LMAX) ? LEVEL_MAX : LEVEL_W'(r);
    end
  end

  assign out_load = (state == SQ_EMIT) && (!out_valid || levels.ready);

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and strobes
  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    log_start     = 1'b0;
    top_req.start = 1'b0;
    top_req.a     = MUL_A_W'(mag);
    top_req.b     = MUL_B_W'(mag);
    case (state)
      SQ_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) state_next = SQ_SMP_MUL;
      end
      SQ_SMP_MUL: begin
        top_req.start = 1'b1;
        state_next    = SQ_SMP_WAIT;
      end
      SQ_SMP_WAIT: begin
        if (mul_rsp.done) state_next = SQ_CHECK;
      end
      SQ_CHECK: begin
        state_next = blk_close ? SQ_LOG_START : SQ_IDLE;
      end
      SQ_LOG_START: begin
        if (energy_zero) begin
          if (job == JOB_BLOCK_ENERGY && long_close) state_next = SQ_LOG_START;
          else state_next = SQ_EMIT;
        end else begin
          log_start  = 1'b1;
          state_next = SQ_LOG_WAIT;
        end
      end
      SQ_LOG_WAIT: begin
        if (log_done) state_next = energy_job ? SQ_LOG_START : SQ_LVL_MUL;
      end
      SQ_LVL_MUL: begin
        top_req.start = 1'b1;
        top_req.a     = K_Q28;
        top_req.b     = MUL_B_W'(lvl_mag);
        state_next    = SQ_LVL_WAIT;
      end
      SQ_LVL_WAIT: begin
        if (mul_rsp.done) begin
          if (job == JOB_BLOCK_DIV && long_close) state_next = SQ_LOG_START;
          else state_next = SQ_EMIT;
        end
      end
      SQ_EMIT: begin
        if (out_load) state_next = SQ_IDLE;
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  // accumulators and period counters
  always_ff @(posedge clk) begin
    if (rst) begin
      block_energy <= '0;
      long_energy  <= '0;
      sample_index <= '0;
      block_index  <= '0;
      long_close   <= 1'b0;
      job          <= JOB_BLOCK_ENERGY;
    end else begin
      case (state)
        SQ_SMP_WAIT: begin
          if (mul_rsp.done) block_energy <= block_energy + BE_W'(mul_rsp.p);
        end
        SQ_CHECK: begin
          if (blk_close) begin
            sample_index <= '0;
            block_energy <= '0;
            long_close   <= long_close_now;
            job          <= JOB_BLOCK_ENERGY;
            if (long_close_now) begin
              block_index <= '0;
              long_energy <= '0;
            end else begin
              block_index <= bidx_inc[BPL_W-1:0];
              long_energy <= long_sum;
            end
          end else begin
            sample_index <= sidx_inc[BL_W-1:0];
          end
        end
        SQ_LOG_START: begin
          if (energy_zero && job == JOB_BLOCK_ENERGY) job <= JOB_LONG_ENERGY;
        end
        SQ_LOG_WAIT: begin
          if (log_done && energy_job) begin
            job <= (job == JOB_BLOCK_ENERGY) ? JOB_BLOCK_DIV : JOB_LONG_DIV;
          end
        end
        SQ_LVL_WAIT: begin
          if (mul_rsp.done && job == JOB_BLOCK_DIV) job <= JOB_LONG_ENERGY;
        end
        default: ;
      endcase
    end
  end

  // payload: sample magnitude, energy snapshots, logs, result fields
  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) mag <= mag_in;
    case (state)
      SQ_CHECK: begin
        if (blk_close) begin
          e_blk            <= block_energy;
          e_long           <= long_sum;
          res.block_level  <= '0;
          res.block_silent <= 1'b0;
          res.long_valid   <= long_close_now;
          res.long_level   <= '0;
          res.long_silent  <= 1'b0;
        end
      end
      SQ_LOG_START: begin
        if (energy_zero) begin
          if (job == JOB_BLOCK_ENERGY) begin
            res.block_level  <= LEVEL_MIN;
            res.block_silent <= 1'b1;
          end else begin
            res.long_level  <= LEVEL_MIN;
            res.long_silent <= 1'b1;
          end
        end
      end
      SQ_LOG_WAIT: begin
        if (log_done) begin
          if (energy_job) la <= log_res;
          else lb <= log_res;
        end
      end
      SQ_LVL_MUL: begin
        neg_reg <= lvl_neg;
      end
      SQ_LVL_WAIT: begin
        if (mul_rsp.done) begin
          if (job == JOB_BLOCK_DIV) res.block_level <= lvl;
          else res.long_level <= lvl;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !levels.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= res;
  end

  assign levels.valid = out_valid;
  assign levels.data  = out_data;

endmodule

[test/rms_db_level_meter_tb.sv]
// rms_db_level_meter_tb: self-checking bench for the rms dB level meter.
// Walks a directed table, then random phases under several register settings.
// Depends on rdb_pkg, rdb_chan_if and the rms_db_level_meter RTL.
`timescale 1ns / 100ps

module rms_db_level_meter_tb;
  import rdb_pkg::*;

  localparam int BL_MAX         = 1024;
  localparam int BPL_MAX        = 16;
  localparam int SETTLE_CYCLES  = 1000;
  localparam int RX_HOLD_CYCLES = 3000;
  localparam int TIMEOUT_NS     = 150_000_000;
  localparam int MAX_REPORTS    = 10;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -16'sd9000;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 16'sd23200;
  localparam logic [63:0] TEN_LOG10_2_Q28 = 64'd808071242;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam level_item_t NO_LEVEL = '0;
  localparam level_item_t SILENT_BOTH = '{block_level: LEVEL_MIN, block_silent: 1'b1,
                                          long_valid: 1'b1, long_level: LEVEL_MIN,
                                          long_silent: 1'b1};
  localparam level_item_t SILENT_BLOCK = '{block_level: LEVEL_MIN, block_silent: 1'b1,
                                           long_valid: 1'b0, long_level: '0,
                                           long_silent: 1'b0};
  localparam level_item_t ZERO_DB_BOTH = '{block_level: '0, block_silent: 1'b0,
                                           long_valid: 1'b1, long_level: '0,
                                           long_silent: 1'b0};

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DATA_W-1:0]      data;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       typed;
    level_item_t                want;
  } dir_row_t;

  typedef struct packed {
    int bl;
    int bpl;
    int count;
    bit quiet;
  } phase_t;

  // Directed table: extremes, silence, register masking/clamping, spare
  // indexes, and a block length lowered under a running count.
  dir_row_t dir_rows [24] = '{
    '{ROW_WRITE,  REG_BLOCK_LENGTH,    11'd1,     16'sd0,      1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_BLOCKS_PER_LONG, 11'd1,     16'sd0,      1'b0, NO_LEVEL},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     16'sd0,      1'b1, SILENT_BOTH},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     16'sd1,      1'b1, ZERO_DB_BOTH},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     -16'sd1,     1'b1, ZERO_DB_BOTH},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     16'sh7FFF,   1'b0, NO_LEVEL},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     16'sh8000,   1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_BLOCKS_PER_LONG, 11'h022,   16'sd0,      1'b0, NO_LEVEL},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     16'sd0,      1'b1, SILENT_BLOCK},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     16'sd1,      1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_BLOCKS_PER_LONG, 11'd0,     16'sd0,      1'b0, NO_LEVEL},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     16'sd0,      1'b1, SILENT_BOTH},
    '{ROW_WRITE,  REG_BLOCK_LENGTH,    11'd0,     16'sd0,      1'b0, NO_LEVEL},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     16'sd5,      1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_SPARE_A,         11'h7FF,   16'sd0,      1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_SPARE_B,         11'd0,     16'sd0,      1'b0, NO_LEVEL},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     16'sh8000,   1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_BLOCK_LENGTH,    11'd4,     16'sd0,      1'b0, NO_LEVEL},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     16'sd100,    1'b0, NO_LEVEL},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     -16'sd100,   1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_BLOCK_LENGTH,    11'd2,     16'sd0,      1'b0, NO_LEVEL},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     16'sd3,      1'b0, NO_LEVEL},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     16'sh5555,   1'b0, NO_LEVEL},
    '{ROW_SAMPLE, REG_BLOCK_LENGTH,    11'd0,     16'shAAAA,   1'b0, NO_LEVEL}
  };

  // Random phases: raw register writes (0 and over-range on purpose), item count.
  // The quiet phase runs one block of near silence at the longest block length.
  phase_t phases [10] = '{
    '{1,    1,  60,   1'b0},
    '{2,    3,  100,  1'b0},
    '{16,   31, 200,  1'b0},
    '{5,    2,  100,  1'b0},
    '{37,   7,  150,  1'b0},
    '{8,    4,  100,  1'b0},
    '{3,    10, 100,  1'b0},
    '{2047, 1,  1024, 1'b1},
    '{0,    0,  60,   1'b0},
    '{12,   5,  50,   1'b0}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rdb_sample_if smp_ch ();
  rdb_level_if  lvl_ch ();

  rms_db_level_meter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (smp_ch),
    .levels    (lvl_ch)
  );

  // Meter model state and configuration
  logic [63:0] blk_energy;
  logic [63:0] long_energy;
  int unsigned smp_cnt;
  int unsigned blk_cnt;
  int unsigned cur_bl;
  int unsigned cur_bpl;

  level_item_t expected_levels [$];

  int errors;
  int n_items;
  int n_results;
  int n_long;
  int n_silent;
  int n_floor;
  int n_writes;
  int tx_idle_pct;
  int rx_stall_pct;
  logic hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // log2 in Q24: leading-one position plus 24 fraction bits by repeated squaring
  function automatic logic [63:0] fix_log2(input logic [63:0] x);
    int unsigned e;
    int          i;
    logic [63:0] m;
    logic [63:0] frac;
    e = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e >= 30) m = x >> (e - 30);
    else m = x << (30 - e);
    frac = '0;
    for (i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(e) << LOG_FRAC) | frac;
  endfunction

  // 10*log10(num/den) in 1/256 dB, rounded half away from zero, clamped
  function automatic logic signed [LEVEL_W-1:0] db_level(input logic [63:0] num,
                                                         input logic [63:0] den);
    logic [63:0] ln;
    logic [63:0] ld;
    logic [63:0] diff;
    logic [63:0] r;
    logic        neg;
    longint      v;
    ln = fix_log2(num);
    ld = fix_log2(den);
    neg = ln < ld;
    diff = neg ? (ld - ln) : (ln - ld);
    r = (diff * TEN_LOG10_2_Q28 + (64'd1 << 43)) >> 44;
    if (r > 64'd1000000) r = 64'd1000000;
    v = neg ? -longint'(r) : longint'(r);
    if (v < longint'(LEVEL_MIN)) v = longint'(LEVEL_MIN);
    if (v > longint'(LEVEL_MAX)) v = longint'(LEVEL_MAX);
    return 16'(v);
  endfunction

  // Advance the meter by one sample; returns 1 with the level item on a block close
  function automatic bit next_level(input logic signed [SAMPLE_W-1:0] s,
                                    output level_item_t lv);
    int          sv;
    logic [63:0] mag;
    sv = s;
    mag = (sv < 0) ? 64'(-sv) : 64'(sv);
    lv = '0;
    blk_energy += mag * mag;
    if (smp_cnt + 1 < cur_bl) begin
      smp_cnt++;
      return 1'b0;
    end
    smp_cnt = 0;
    if (blk_energy == 0) begin
      lv.block_level  = LEVEL_MIN;
      lv.block_silent = 1'b1;
    end else begin
      lv.block_level = db_level(blk_energy, 64'(cur_bl));
    end
    long_energy += blk_energy;
    blk_energy = '0;
    if (blk_cnt + 1 < cur_bpl) begin
      blk_cnt++;
    end else begin
      blk_cnt = 0;
      lv.long_valid = 1'b1;
      if (long_energy == 0) begin
        lv.long_level  = LEVEL_MIN;
        lv.long_silent = 1'b1;
      end else begin
        lv.long_level = db_level(long_energy, 64'(cur_bl) * 64'(cur_bpl));
      end
      long_energy = '0;
    end
    return 1'b1;
  endfunction

  task automatic settle();
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write once the meter is idle; mirrors masking and clamping
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    int unsigned v;
    smp_ch.valid <= 1'b0;
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_writes++;
    case (idx)
      REG_BLOCK_LENGTH: begin
        v = data;
        if (v == 0) v = 1;
        if (v > BL_MAX) v = BL_MAX;
        cur_bl = v;
      end
      REG_BLOCKS_PER_LONG: begin
        v = data & 11'h01F;
        if (v == 0) v = 1;
        if (v > BPL_MAX) v = BPL_MAX;
        cur_bpl = v;
      end
      default: ;
    endcase
  endtask

  // Offer one sample with random idle cycles ahead of it; predict on acceptance
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic typed,
                             input level_item_t typed_want);
    level_item_t lv;
    bit          closes;
    while ($urandom_range(99) < tx_idle_pct) begin
      smp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    smp_ch.valid       <= 1'b1;
    smp_ch.data.sample <= s;
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
    n_items++;
    closes = next_level(s, lv);
    if (typed) expected_levels.push_back(typed_want);
    else if (closes) expected_levels.push_back(lv);
  endtask

  task automatic flag(input string what, input level_item_t want, input level_item_t got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%0t %s: want lvl %0d sil %0b long %0b lvl %0d sil %0b",
               $realtime, what,
               want.block_level, want.block_silent, want.long_valid,
               want.long_level, want.long_silent);
      $display("    got lvl %0d sil %0b long %0b lvl %0d sil %0b",
               got.block_level, got.block_silent, got.long_valid,
               got.long_level, got.long_silent);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when asked
  initial begin
    logic hold_ack;
    int   hold_left;
    hold_ack = 1'b0;
    hold_left = 0;
    lvl_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        lvl_ch.ready <= 1'b0;
      end else begin
        lvl_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Output checker: each accepted level item against the oldest expectation
  always @(posedge clk) begin
    level_item_t want;
    level_item_t got;
    if (!rst && lvl_ch.valid && lvl_ch.ready) begin
      got = lvl_ch.data;
      n_results++;
      if (got.block_silent) n_silent++;
      if (got.long_valid) n_long++;
      if (got.long_valid && !got.long_silent && got.long_level == LEVEL_MIN) n_floor++;
      if (expected_levels.size() == 0) begin
        flag("level item with none expected", NO_LEVEL, got);
      end else begin
        want = expected_levels.pop_front();
        if (got.block_level !== want.block_level || got.block_silent !== want.block_silent ||
            got.long_valid !== want.long_valid || got.long_level !== want.long_level ||
            got.long_silent !== want.long_silent)
          flag("level item mismatch", want, got);
      end
    end
  end

  // Stimulus
  initial begin
    int                         p;
    int                         k;
    int                         blip_at;
    logic signed [SAMPLE_W-1:0] s;
    phase_t                     ph;

    errors = 0;
    n_items = 0;
    n_results = 0;
    n_long = 0;
    n_silent = 0;
    n_floor = 0;
    n_writes = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    blk_energy = '0;
    long_energy = '0;
    smp_cnt = 0;
    blk_cnt = 0;
    cur_bl = BL_RESET;
    cur_bpl = BPL_RESET;

    rst                <= 1'b1;
    hold_req           <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_BLOCK_LENGTH;
    cfg_data           <= '0;
    smp_ch.valid       <= 1'b0;
    smp_ch.data.sample <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (k = 0; k < $size(dir_rows); k++) begin
      if (dir_rows[k].kind == ROW_WRITE) write_reg(dir_rows[k].idx, dir_rows[k].data);
      else push_sample(dir_rows[k].sample, dir_rows[k].typed, dir_rows[k].want);
    end

    // Random phases, cycling the idling patterns
    for (p = 0; p < $size(phases); p++) begin
      ph = phases[p];
      write_reg(REG_BLOCK_LENGTH, 11'(ph.bl));
      write_reg(REG_BLOCKS_PER_LONG, 11'(ph.bpl));
      case (p % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 78; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 78; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      // every sample closes a block here, so a held-off receiver backs up the input
      if (p == 0) hold_req <= ~hold_req;
      blip_at = $urandom_range(ph.count - 1);
      for (k = 0; k < ph.count; k++) begin
        if (p == 1 && k == ph.count / 2) begin
          smp_ch.valid <= 1'b0;
          @(posedge clk);
          while (expected_levels.size() != 0) @(posedge clk);
        end
        if (ph.quiet) begin
          // one unit sample in the whole block
          if (k == blip_at) s = $urandom_range(1) ? 16'sd1 : -16'sd1;
          else s = '0;
        end else begin
          case ($urandom_range(7))
            0: s = '0;
            1: begin
              case ($urandom_range(3))
                0:       s = 16'sh7FFF;
                1:       s = 16'sh8000;
                2:       s = 16'sd1;
                default: s = -16'sd1;
              endcase
            end
            2:       s = 16'($urandom_range(31)) - 16'sd16;
            default: s = 16'($urandom());
          endcase
        end
        push_sample(s, 1'b0, NO_LEVEL);
      end
    end

    smp_ch.valid <= 1'b0;
    settle();
    errors += expected_levels.size();

    $display("Sent %0d samples over %0d register writes; checked %0d level items",
             n_items, n_writes, n_results);
    $display("(%0d long periods, %0d silent blocks, %0d long levels clamped at floor)",
             n_long, n_silent, n_floor);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
